>>> design/doubly_linked_list_manager_unit_assert.svh
// Assertion macros shared by the list manager RTL.
`ifndef DOUBLY_LINKED_LIST_MANAGER_UNIT_ASSERT_SVH
`define DOUBLY_LINKED_LIST_MANAGER_UNIT_ASSERT_SVH

// Same-cycle implication, held off while reset is asserted.
`define DLLM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define DLLM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/dllm_pkg.sv
`timescale 1ns / 1ps

package dllm_pkg;

	// Command codes on the command port
	typedef enum logic [1:0] {
		CMD_INS_AFTER  = 2'd0,
		CMD_INS_BEFORE = 2'd1,
		CMD_DETACH     = 2'd2
	} cmd_t;

	// Sequencer states, one-hot
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_S1   = 3'b010,
		ST_S2   = 3'b100
	} state_t;

	// Node index ports are a byte wide; list length port is 9 bits
	localparam int NODE_PORT_W = 8;
	localparam int LEN_PORT_W  = 9;
	localparam int SLOT_N      = 1 << NODE_PORT_W;

endpackage

>>> design/doubly_linked_list_manager_unit.sv
`timescale 1ns / 1ps

// Doubly linked list manager over a pool of NODE_COUNT nodes. A request is
// taken when start is high and busy is low; it runs through the accept
// cycle plus two sequencer steps (S1, S2), and busy stays high in both steps,
// so no new request is taken until they are through. That is set by the
// single write port of each link memory: an anchored insert writes the same
// link memory twice after the neighbor read. The result is registered at the
// end of step S2 and shows on the result ports with done high for exactly one
// cycle; the receiver cannot stall, so it must take the result in that cycle.
// Link memories need no clearing pass after reset: only head, tail, length,
// the sequencer state and done are reset, and an empty list never reads a link.
// Node indices on the ports are reduced modulo NODE_COUNT before use.
`include "doubly_linked_list_manager_unit_assert.svh"

module doubly_linked_list_manager_unit #(
	parameter int NODE_COUNT = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] command,
	input  logic [7:0] anchor_node,
	input  logic       anchor_none,
	input  logic [7:0] subject_node,
	output logic       done,
	output logic [7:0] head_node,
	output logic       head_none,
	output logic [7:0] tail_node,
	output logic       tail_none,
	output logic [8:0] list_length,
	output logic [7:0] returned_node
);

	localparam int IW = $clog2(NODE_COUNT);
	localparam int LW = IW + 1;
	localparam int CW = $clog2(NODE_COUNT + 1);
	localparam int PW = dllm_pkg::NODE_PORT_W;
	localparam int NW = dllm_pkg::LEN_PORT_W;
	localparam logic [CW-1:0] CNT_MAX  = CW'(NODE_COUNT);
	localparam logic [LW-1:0] NONE_LNK = {1'b1, {IW{1'b0}}};

	typedef logic [IW-1:0] slot_tbl_t [dllm_pkg::SLOT_N];

	// Port index to pool slot, folded at elaboration
	function automatic slot_tbl_t build_slot_tbl();
		slot_tbl_t t;
		for (int i = 0; i < dllm_pkg::SLOT_N; i++) begin
			t[i] = IW'(i % NODE_COUNT);
		end
		return t;
	endfunction

	localparam slot_tbl_t SLOT_TBL = build_slot_tbl();

	function automatic logic [LW-1:0] mk_link(input logic [IW-1:0] idx);
		return {1'b0, idx};
	endfunction

	function automatic logic [LW-1:0] anchor_none_sel(input logic sel,
			input logic [LW-1:0] end_lnk, input logic [LW-1:0] rd_lnk);
		return sel ? end_lnk : rd_lnk;
	endfunction

	dllm_pkg::state_t state_q;

	logic [LW-1:0] next_mem [NODE_COUNT];
	logic [LW-1:0] prev_mem [NODE_COUNT];
	logic [LW-1:0] next_rd_s1;
	logic [LW-1:0] prev_rd_s1;

	logic [IW-1:0] a_in;
	logic [IW-1:0] s_in;
	logic [IW-1:0] rd_addr;
	logic          accept;

	logic [1:0]    cmd_q;
	logic [IW-1:0] a_q;
	logic          anone_q;
	logic [IW-1:0] s_q;
	logic [7:0]    sub_raw_q;

	logic [LW-1:0] head_q;
	logic [LW-1:0] tail_q;
	logic [CW-1:0] count_q;
	logic [LW-1:0] head_d;
	logic [LW-1:0] tail_d;
	logic [CW-1:0] count_d;

	logic          nx_we;
	logic [IW-1:0] nx_waddr;
	logic [LW-1:0] nx_wdata;
	logic          pv_we;
	logic [IW-1:0] pv_waddr;
	logic [LW-1:0] pv_wdata;

	logic [LW-1:0] nb_lnk;

	logic          done_q;
	logic [7:0]    head_node_q;
	logic          head_none_q;
	logic [7:0]    tail_node_q;
	logic          tail_none_q;
	logic [8:0]    list_length_q;
	logic [7:0]    returned_node_q;

	logic [IW+PW-1:0] head_ext;
	logic [IW+PW-1:0] tail_ext;
	logic [CW+NW-1:0] cnt_ext;

	// Fold request indices into the pool
	assign a_in    = SLOT_TBL[anchor_node];
	assign s_in    = SLOT_TBL[subject_node];
	assign busy    = (state_q != dllm_pkg::ST_IDLE);
	assign accept  = start && !busy;
	assign rd_addr = (command == dllm_pkg::CMD_DETACH) ? s_in : a_in;

	// Link memories: one write and one registered read per cycle each
	always_ff @(posedge clk) begin
		if (nx_we) begin
			next_mem[nx_waddr] <= nx_wdata;
		end
		if (pv_we) begin
			prev_mem[pv_waddr] <= pv_wdata;
		end
		next_rd_s1 <= next_mem[rd_addr];
		prev_rd_s1 <= prev_mem[rd_addr];
	end

	// Sequence link writes and list updates per command
	always_comb begin
		nx_we    = 1'b0;
		nx_waddr = '0;
		nx_wdata = '0;
		pv_we    = 1'b0;
		pv_waddr = '0;
		pv_wdata = '0;
		head_d   = head_q;
		tail_d   = tail_q;
		count_d  = count_q;
		nb_lnk   = '0;
		unique case (state_q)
			dllm_pkg::ST_IDLE: begin
				// Link the subject toward its anchor right at accept
				if (accept) begin
					case (command)
						dllm_pkg::CMD_INS_AFTER: begin
							pv_we    = 1'b1;
							pv_waddr = s_in;
							pv_wdata = anchor_none ? NONE_LNK : mk_link(a_in);
						end
						dllm_pkg::CMD_INS_BEFORE: begin
							nx_we    = 1'b1;
							nx_waddr = s_in;
							nx_wdata = anchor_none ? NONE_LNK : mk_link(a_in);
						end
						default: ;
					endcase
				end
			end
			dllm_pkg::ST_S1: begin
				case (cmd_q)
					dllm_pkg::CMD_INS_AFTER: begin
						nx_we    = 1'b1;
						nx_waddr = s_q;
						nx_wdata = anchor_none_sel(anone_q, head_q, next_rd_s1);
						// Successor as it stands once the anchor points at the subject
						if (anone_q) begin
							nb_lnk = head_q;
							head_d = mk_link(s_q);
						end else if (s_q == a_q) begin
							nb_lnk = mk_link(s_q);
						end else begin
							nb_lnk = next_rd_s1;
						end
						if (nb_lnk[IW]) begin
							tail_d = mk_link(s_q);
						end else begin
							pv_we    = 1'b1;
							pv_waddr = nb_lnk[IW-1:0];
							pv_wdata = mk_link(s_q);
						end
						if (count_q < CNT_MAX) begin
							count_d = count_q + 1'b1;
						end
					end
					dllm_pkg::CMD_INS_BEFORE: begin
						pv_we    = 1'b1;
						pv_waddr = s_q;
						pv_wdata = anchor_none_sel(anone_q, tail_q, prev_rd_s1);
						// Predecessor as it stands once the anchor points at the subject
						if (anone_q) begin
							nb_lnk = tail_q;
							tail_d = mk_link(s_q);
						end else if (s_q == a_q) begin
							nb_lnk = mk_link(s_q);
						end else begin
							nb_lnk = prev_rd_s1;
						end
						if (nb_lnk[IW]) begin
							head_d = mk_link(s_q);
						end else begin
							nx_we    = 1'b1;
							nx_waddr = nb_lnk[IW-1:0];
							nx_wdata = mk_link(s_q);
						end
						if (count_q < CNT_MAX) begin
							count_d = count_q + 1'b1;
						end
					end
					dllm_pkg::CMD_DETACH: begin
						// Bridge the neighbors of the subject
						if (prev_rd_s1[IW]) begin
							head_d = next_rd_s1;
						end else begin
							nx_we    = 1'b1;
							nx_waddr = prev_rd_s1[IW-1:0];
							nx_wdata = next_rd_s1;
						end
						if (next_rd_s1[IW]) begin
							tail_d = prev_rd_s1;
						end else begin
							pv_we    = 1'b1;
							pv_waddr = next_rd_s1[IW-1:0];
							pv_wdata = prev_rd_s1;
						end
						if (count_q != '0) begin
							count_d = count_q - 1'b1;
						end
					end
					default: ;
				endcase
			end
			dllm_pkg::ST_S2: begin
				// Point an anchor at the subject last
				if (!anone_q && cmd_q == dllm_pkg::CMD_INS_AFTER) begin
					nx_we    = 1'b1;
					nx_waddr = a_q;
					nx_wdata = mk_link(s_q);
				end else if (!anone_q && cmd_q == dllm_pkg::CMD_INS_BEFORE) begin
					pv_we    = 1'b1;
					pv_waddr = a_q;
					pv_wdata = mk_link(s_q);
				end
			end
			default: ;
		endcase
	end

	// Advance the sequencer and hold list state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dllm_pkg::ST_IDLE;
			head_q  <= NONE_LNK;
			tail_q  <= NONE_LNK;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
			done_q  <= (state_q == dllm_pkg::ST_S2);
			unique case (state_q)
				dllm_pkg::ST_IDLE: begin
					if (accept) begin
						state_q <= dllm_pkg::ST_S1;
					end
				end
				dllm_pkg::ST_S1: state_q <= dllm_pkg::ST_S2;
				dllm_pkg::ST_S2: state_q <= dllm_pkg::ST_IDLE;
				default:         state_q <= dllm_pkg::ST_IDLE;
			endcase
		end
	end

	// Capture the request
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= command;
			a_q       <= a_in;
			anone_q   <= anchor_none;
			s_q       <= s_in;
			sub_raw_q <= subject_node;
		end
	end

	assign head_ext = {{PW{1'b0}}, head_q[IW-1:0]};
	assign tail_ext = {{PW{1'b0}}, tail_q[IW-1:0]};
	assign cnt_ext  = {{NW{1'b0}}, count_q};

	// Load the result once the list state has settled
	always_ff @(posedge clk) begin
		if (state_q == dllm_pkg::ST_S2) begin
			head_node_q     <= head_q[IW] ? 8'd0 : head_ext[PW-1:0];
			head_none_q     <= head_q[IW];
			tail_node_q     <= tail_q[IW] ? 8'd0 : tail_ext[PW-1:0];
			tail_none_q     <= tail_q[IW];
			list_length_q   <= cnt_ext[NW-1:0];
			returned_node_q <= sub_raw_q;
		end
	end

	assign done          = done_q;
	assign head_node     = head_node_q;
	assign head_none     = head_none_q;
	assign tail_node     = tail_node_q;
	assign tail_none     = tail_none_q;
	assign list_length   = list_length_q;
	assign returned_node = returned_node_q;

	`DLLM_ASSERT_NXT(a_accept_seq, clk, arst_n, accept, state_q == dllm_pkg::ST_S1, "accept did not start sequence")
	`DLLM_ASSERT_NXT(a_s2_done, clk, arst_n, state_q == dllm_pkg::ST_S2, done && !busy, "no result after last step")
	`DLLM_ASSERT_IMP(a_done_src, clk, arst_n, done, $past(state_q == dllm_pkg::ST_S2), "stray result strobe")
	`DLLM_ASSERT_IMP(a_count_max, clk, arst_n, 1'b1, count_q <= CNT_MAX, "length above pool size")

endmodule
